// ===== rtl/sparse_default_vector_pattern_sum_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sparse vector pattern-sum block
// Each macro expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef SPARSE_DEFAULT_VECTOR_PATTERN_SUM_ASSERT_SVH
`define SPARSE_DEFAULT_VECTOR_PATTERN_SUM_ASSERT_SVH

// same-cycle implication
`define SDVPS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SDVPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sdvps_pkg.sv =====
// ----------------------------------------------------------------------------
// sdvps_pkg
// Shared types and constants of the sparse vector pattern-sum block.
// ----------------------------------------------------------------------------
package sdvps_pkg;

    localparam int SDVPS_CAPACITY = 64;
    localparam int SDVPS_ID_BITS  = 16;
    localparam int VALUE_W        = 16;
    localparam int SUM_W          = 32;
    localparam int LIMIT_W        = 7;

    localparam logic [2:0] ACT_INSERT = 3'd0;
    localparam logic [2:0] ACT_ADD    = 3'd1;
    localparam logic [2:0] ACT_SUB    = 3'd2;
    localparam logic [2:0] ACT_LOOKUP = 3'd3;
    localparam logic [2:0] ACT_CLEAR  = 3'd4;

    localparam logic REG_DEFAULT_VALUE = 1'b0;
    localparam logic REG_SIZE_LIMIT    = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FINISH
    } state_t;

    // per-cell control from the top level
    typedef struct packed {
        logic ins_en;   // insert transfer being applied this cycle
        logic valid;    // cell index below entry count
        logic tail;     // cell index equals entry count
    } cell_ctrl_t;

    // per-cell status handed to the next cell and to the top level
    typedef struct packed {
        logic gt;       // stored id above the key
        logic match;    // stored id equals the key
        logic first;    // first match of the run
    } cell_stat_t;

endpackage

// ===== rtl/sdvps_cell.sv =====
// ----------------------------------------------------------------------------
// sdvps_cell
// One entry of the sorted store: compares its id with the key, shifts in
// from its left neighbor or takes the new entry on insert.
// ----------------------------------------------------------------------------
module sdvps_cell
    import sdvps_pkg::*;
#(
    parameter int ID_BITS = SDVPS_ID_BITS
)
(
    input  logic                      clk,
    input  cell_ctrl_t                ctrl,
    input  logic [ID_BITS-1:0]        key,
    input  logic [VALUE_W-1:0]        new_value,
    input  logic [ID_BITS-1:0]        prev_id,
    input  logic [VALUE_W-1:0]        prev_value,
    input  cell_stat_t                prev_stat,
    output logic [ID_BITS-1:0]        id_out,
    output logic [VALUE_W-1:0]        value_out,
    output cell_stat_t                stat,
    output logic [VALUE_W-1:0]        hit_value
);

    logic [ID_BITS-1:0] id_reg;
    logic [VALUE_W-1:0] value_reg;

    always_comb
    begin
        stat.gt    = ctrl.valid && (id_reg > key);
        stat.match = ctrl.valid && (id_reg == key);
        // store is sorted, so matches form one run
        stat.first = stat.match && !prev_stat.match;
        hit_value  = stat.first ? value_reg : '0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ins_en)
        begin
            if (prev_stat.gt)
            begin
                id_reg    <= prev_id;
                value_reg <= prev_value;
            end
            else if (stat.gt || ctrl.tail)
            begin
                id_reg    <= key;
                value_reg <= new_value;
            end
        end
    end

    assign id_out    = id_reg;
    assign value_out = value_reg;

endmodule

// ===== rtl/sparse_default_vector_pattern_sum.sv =====
// ----------------------------------------------------------------------------
// sparse_default_vector_pattern_sum
// Sorted sparse vector with default value, pattern gather-sum and lookup.
// ----------------------------------------------------------------------------
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  input   | in_valid/in_ready, action, element_id,          | in
//          | membership, base_sum, last                      |
//  output  | out_valid/out_ready, result_value, is_full,     | out
//          | rejected                                        |
//  config  | cfg_valid/cfg_ready, cfg_index, cfg_data        | in
//
//  Each item passes through EXEC, in which the cell row compares, shifts for
//  an insert and reduces the match, and then FINISH, which updates the sum
//  and the output register. The next item is taken in FINISH.
//  Reset empties the store and the open pattern; no clearing pass is needed.
//  An item with a result holds in FINISH while the output register
//  is full and not being drained. Config writes are taken in any cycle.
// ----------------------------------------------------------------------------
module sparse_default_vector_pattern_sum
    import sdvps_pkg::*;
#(
    parameter int CAPACITY = SDVPS_CAPACITY,
    parameter int ID_BITS  = SDVPS_ID_BITS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [2:0]                action,
    input  logic [ID_BITS-1:0]        element_id,
    input  logic signed [VALUE_W-1:0] membership,
    input  logic signed [SUM_W-1:0]   base_sum,
    input  logic                      last,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [SUM_W-1:0]   result_value,
    output logic                      is_full,
    output logic                      rejected,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      cfg_index,
    input  logic [VALUE_W-1:0]        cfg_data
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    state_t              state_reg, state_next;

    logic [2:0]          act_reg;
    logic [ID_BITS-1:0]  id_reg;
    logic [VALUE_W-1:0]  memb_reg;
    logic [SUM_W-1:0]    base_reg;
    logic                last_reg;

    logic [VALUE_W-1:0]  default_reg;
    logic [LIMIT_W-1:0]  limit_reg;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [SUM_W-1:0]    acc_reg, acc_next;
    logic                inpat_reg, inpat_next;

    logic [VALUE_W-1:0]  look_reg;
    logic                rej_reg;

    logic                out_valid_reg, out_valid_next;
    logic [SUM_W-1:0]    out_value_reg, out_value_next;
    logic                out_full_reg, out_full_next;
    logic                out_rej_reg, out_rej_next;

    logic                full_now;
    logic                has_result;
    logic                can_finish;
    logic                exec_ins;
    logic [SUM_W-1:0]    look_ext;
    logic [SUM_W-1:0]    acc_seed;

    logic [ID_BITS-1:0]  cell_id    [CAPACITY];
    logic [VALUE_W-1:0]  cell_value [CAPACITY];
    logic [VALUE_W-1:0]  cell_hit   [CAPACITY];
    cell_stat_t          cell_stat  [CAPACITY];
    logic [CAPACITY-1:0] first_vec;
    logic [VALUE_W-1:0]  hit_or;

    assign full_now = (CMP_W'(count_reg) >= CMP_W'(limit_reg))
                   || (count_reg == CNT_W'(CAPACITY));
    assign exec_ins = (state_reg == ST_EXEC) && (act_reg == ACT_INSERT) && !full_now;

    // ---------------- cell row ----------------
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            cell_ctrl_t         ctrl;
            logic [ID_BITS-1:0] p_id;
            logic [VALUE_W-1:0] p_val;
            cell_stat_t         p_stat;

            assign ctrl.ins_en = exec_ins;
            assign ctrl.valid  = CNT_W'(g) < count_reg;
            assign ctrl.tail   = CNT_W'(g) == count_reg;

            if (g == 0)
            begin : g_head
                assign p_id   = '0;
                assign p_val  = '0;
                assign p_stat = '0;
            end
            else
            begin : g_body
                assign p_id   = cell_id[g-1];
                assign p_val  = cell_value[g-1];
                assign p_stat = cell_stat[g-1];
            end

            sdvps_cell #(
                .ID_BITS (ID_BITS)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .key        (id_reg),
                .new_value  (memb_reg),
                .prev_id    (p_id),
                .prev_value (p_val),
                .prev_stat  (p_stat),
                .id_out     (cell_id[g]),
                .value_out  (cell_value[g]),
                .stat       (cell_stat[g]),
                .hit_value  (cell_hit[g])
            );

            assign first_vec[g] = cell_stat[g].first;
        end
    endgenerate

    // at most one cell drives a nonzero hit value
    always_comb
    begin
        hit_or = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            hit_or = hit_or | cell_hit[k];
        end
    end

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_reg <= '0;
            limit_reg   <= LIMIT_W'(64);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_DEFAULT_VALUE: default_reg <= cfg_data;
                REG_SIZE_LIMIT:    limit_reg   <= cfg_data[LIMIT_W-1:0];
                default:           ;
            endcase
        end
    end

    // ---------------- control ----------------
    assign look_ext = {{(SUM_W-VALUE_W){look_reg[VALUE_W-1]}}, look_reg};
    assign acc_seed = inpat_reg ? acc_reg : base_reg;

    always_comb
    begin
        case (act_reg)
            ACT_INSERT: has_result = 1'b1;
            ACT_ADD:    has_result = last_reg;
            ACT_SUB:    has_result = last_reg;
            ACT_LOOKUP: has_result = 1'b1;
            default:    has_result = 1'b0;
        endcase
    end

    assign can_finish = !has_result || !out_valid_reg || out_ready;
    assign in_ready   = (state_reg == ST_IDLE) || ((state_reg == ST_FINISH) && can_finish);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        acc_next       = acc_reg;
        inpat_next     = inpat_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_value_next = out_value_reg;
        out_full_next  = out_full_reg;
        out_rej_next   = out_rej_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_ins)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                else if (act_reg == ACT_CLEAR)
                begin
                    count_next = '0;
                end
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (can_finish)
                begin
                    case (act_reg)
                        ACT_INSERT:
                        begin
                            out_value_next = '0;
                        end
                        ACT_ADD:
                        begin
                            acc_next   = acc_seed + look_ext;
                            inpat_next = !last_reg;
                            // mid-pattern ids leave a waiting result alone
                            if (last_reg)
                            begin
                                out_value_next = acc_seed + look_ext;
                            end
                        end
                        ACT_SUB:
                        begin
                            acc_next   = acc_seed - look_ext;
                            inpat_next = !last_reg;
                            if (last_reg)
                            begin
                                out_value_next = acc_seed - look_ext;
                            end
                        end
                        ACT_LOOKUP:
                        begin
                            out_value_next = look_ext;
                        end
                        ACT_CLEAR:
                        begin
                            acc_next   = '0;
                            inpat_next = 1'b0;
                        end
                        default: ;
                    endcase
                    if (has_result)
                    begin
                        out_valid_next = 1'b1;
                        out_full_next  = full_now;
                        out_rej_next   = (act_reg == ACT_INSERT) && rej_reg;
                    end
                    state_next = in_valid ? ST_EXEC : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            acc_reg       <= '0;
            inpat_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            acc_reg       <= acc_next;
            inpat_reg     <= inpat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            act_reg  <= action;
            id_reg   <= element_id;
            memb_reg <= membership;
            base_reg <= base_sum;
            last_reg <= last;
        end
        if (state_reg == ST_EXEC)
        begin
            look_reg <= (|first_vec) ? hit_or : default_reg;
            rej_reg  <= full_now;
        end
        out_value_reg <= out_value_next;
        out_full_reg  <= out_full_next;
        out_rej_reg   <= out_rej_next;
    end

    assign out_valid    = out_valid_reg;
    assign result_value = out_value_reg;
    assign is_full      = out_full_reg;
    assign rejected     = out_rej_reg;

    // ---------------- assertions ----------------
`include "sparse_default_vector_pattern_sum_assert.svh"

    `SDVPS_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(CAPACITY), "count over")
    `SDVPS_ASSERT_NOW(a_reject_full, out_valid && rejected, is_full, "rejected, not full")
    `SDVPS_ASSERT_NEXT(a_accept_exec, in_valid && in_ready, state_reg == ST_EXEC, "no exec")
    `SDVPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_value), "drop")

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Sorted sparse vector with default value: inserts, pattern sums, lookups and
// clears are driven through the valid/ready input channel, with bursty input
// and a stalling output side. A scoreboard tracks the store, the open pattern
// and both registers, and checks every returned item in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import sdvps_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 11;
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_ITEMS    = 125;
    localparam int MAX_GAP        = 6;
    localparam int SETTLE_CYCLES  = 6;
    localparam int DRAIN_LIMIT    = 20000;
    localparam int MAX_REPORTS    = 10;

    // action codes the block ignores
    localparam logic [2:0] ACT_RSVD_FIRST = 3'd5;
    localparam logic [2:0] ACT_RSVD_LAST  = 3'd7;

    typedef struct packed {
        logic [2:0]                action;
        logic [SDVPS_ID_BITS-1:0]  id;
        logic signed [VALUE_W-1:0] memb;
        logic signed [SUM_W-1:0]   base;
        logic                      is_last;
    } vec_op_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] value;
        logic                    full;
        logic                    rej;
    } vec_result_t;

    class vector_scoreboard;
        logic [SDVPS_ID_BITS-1:0]  ids[$];
        logic signed [VALUE_W-1:0] vals[$];
        logic signed [VALUE_W-1:0] default_value;
        logic [LIMIT_W-1:0]        size_limit;
        logic signed [SUM_W-1:0]   acc;
        bit                        pattern_open;
        vec_result_t               expected_q[$];
        int                        failures;
        int                        results_seen;
        int                        rejects_seen;

        function new();
            default_value = '0;
            size_limit    = LIMIT_W'(SDVPS_CAPACITY);
            acc           = '0;
            pattern_open  = 0;
            failures      = 0;
            results_seen  = 0;
            rejects_seen  = 0;
        endfunction

        function void write_reg(logic index, logic [VALUE_W-1:0] data);
            if (index == REG_DEFAULT_VALUE)
                default_value = data;
            else
                size_limit = data[LIMIT_W-1:0];
        endfunction

        function bit full();
            int lim;
            lim = (int'(size_limit) < SDVPS_CAPACITY) ? int'(size_limit) : SDVPS_CAPACITY;
            return ids.size() >= lim;
        endfunction

        // first stored match wins; absent ids read as the default
        function logic signed [VALUE_W-1:0] value_of(logic [SDVPS_ID_BITS-1:0] id);
            foreach (ids[i])
                if (ids[i] == id)
                    return vals[i];
            return default_value;
        endfunction

        function void note_item(vec_op_t op);
            vec_result_t             r;
            int                      pos;
            logic signed [SUM_W-1:0] v;
            r = '0;
            case (op.action)
                ACT_INSERT:
                begin
                    if (full() || ids.size() >= SDVPS_CAPACITY)
                    begin
                        r.rej = 1'b1;
                        rejects_seen++;
                    end
                    else
                    begin
                        // equal ids keep arrival order
                        pos = ids.size();
                        while (pos > 0 && ids[pos-1] > op.id)
                            pos--;
                        ids.insert(pos, op.id);
                        vals.insert(pos, op.memb);
                    end
                    r.full = full();
                    expected_q.push_back(r);
                end
                ACT_ADD, ACT_SUB:
                begin
                    v = SUM_W'(value_of(op.id));
                    if (!pattern_open)
                        acc = op.base;
                    acc = (op.action == ACT_ADD) ? acc + v : acc - v;
                    pattern_open = !op.is_last;
                    if (op.is_last)
                    begin
                        r.value = acc;
                        r.full  = full();
                        expected_q.push_back(r);
                    end
                end
                ACT_LOOKUP:
                begin
                    r.value = SUM_W'(value_of(op.id));
                    r.full  = full();
                    expected_q.push_back(r);
                end
                ACT_CLEAR:
                begin
                    ids.delete();
                    vals.delete();
                    acc          = '0;
                    pattern_open = 0;
                end
                default: ;
            endcase
        endfunction

        function void check_result(vec_result_t got);
            vec_result_t want;
            results_seen++;
            if (expected_q.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("ERROR %0t: extra result: value %0d full %0b rej %0b",
                             $realtime, got.value, got.full, got.rej);
                return;
            end
            want = expected_q.pop_front();
            if (got !== want)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("ERROR %0t: exp/got value %0d/%0d full %0b/%0b rej %0b/%0b",
                             $realtime, want.value, got.value, want.full, got.full,
                             want.rej, got.rej);
            end
        endfunction

        function void check_drained();
            while (expected_q.size() != 0)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("ERROR: result never arrived: value %0d full %0b rej %0b",
                             expected_q[0].value, expected_q[0].full, expected_q[0].rej);
                void'(expected_q.pop_front());
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic [2:0]                action;
    logic [SDVPS_ID_BITS-1:0]  element_id;
    logic signed [VALUE_W-1:0] membership;
    logic signed [SUM_W-1:0]   base_sum;
    logic                      last;
    logic                      out_valid;
    logic                      out_ready;
    logic signed [SUM_W-1:0]   result_value;
    logic                      is_full;
    logic                      rejected;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic                      cfg_index;
    logic [VALUE_W-1:0]        cfg_data;

    vector_scoreboard sb = new();
    int               items_sent;
    int               settings_used;
    int               burst_left;
    bit               gaps_on;

    sparse_default_vector_pattern_sum u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .element_id   (element_id),
        .membership   (membership),
        .base_sum     (base_sum),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_value (result_value),
        .is_full      (is_full),
        .rejected     (rejected),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("timeout: stimulus or results stuck");
        $display("sparse_default_vector_pattern_sum test failed");
        $finish;
    end

    // output side: always ready, random stalls, or a periodic stall pattern
    initial
    begin : sink
        int mode;
        int span;
        int period;
        int hold;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode   = $urandom_range(0, 2);
            span   = $urandom_range(20, 150);
            period = $urandom_range(2, 8);
            hold   = $urandom_range(1, period - 1);
            for (int c = 0; c < span; c++)
            begin
                @(negedge clk);
                case (mode)
                    0: out_ready = 1'b1;
                    1: out_ready = ($urandom_range(0, 99) < 60);
                    default: out_ready = (c % period) >= hold;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        vec_result_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.value = result_value;
            got.full  = is_full;
            got.rej   = rejected;
            sb.check_result(got);
        end
    end

    function automatic vec_op_t make_op(logic [2:0] act, logic [SDVPS_ID_BITS-1:0] id,
                                        logic signed [VALUE_W-1:0] memb,
                                        logic signed [SUM_W-1:0] base, logic fin);
        vec_op_t op;
        op.action  = act;
        op.id      = id;
        op.memb    = memb;
        op.base    = base;
        op.is_last = fin;
        return op;
    endfunction

    function automatic bit coin();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [SDVPS_ID_BITS-1:0] fresh_id();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return SDVPS_ID_BITS'($urandom_range(0, 63));   // dense range: duplicates and hits
        if (r < 8)
            return SDVPS_ID_BITS'($urandom);
        if (r == 8)
            return coin() ? '1 : '0;
        return SDVPS_ID_BITS'($urandom_range(65500, 65535));
    endfunction

    function automatic logic [SDVPS_ID_BITS-1:0] known_or_fresh();
        if (sb.ids.size() > 0 && $urandom_range(0, 3) != 0)
            return sb.ids[$urandom_range(0, sb.ids.size() - 1)];
        return fresh_id();
    endfunction

    function automatic logic signed [VALUE_W-1:0] rand_memb();
        case ($urandom_range(0, 9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [SUM_W-1:0] rand_base();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] add_or_sub();
        return coin() ? ACT_ADD : ACT_SUB;
    endfunction

    task automatic send(vec_op_t op);
        @(negedge clk);
        in_valid   = 1'b1;
        action     = op.action;
        element_id = op.id;
        membership = op.memb;
        base_sum   = op.base;
        last       = op.is_last;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_item(op);
        items_sent++;
    endtask

    // bursts of back-to-back transfers, separated by random gaps when gaps are on
    task automatic issue(vec_op_t op);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if (gaps_on)
            begin
                gap = $urandom_range(1, MAX_GAP);
                @(negedge clk);
                in_valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        send(op);
    endtask

    // idle the input and let every pending result come back
    task automatic quiesce();
        int waited;
        @(negedge clk);
        in_valid = 1'b0;
        waited   = 0;
        while (sb.expected_q.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_reg(logic index, logic [VALUE_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(index, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic ordered_pattern();
        int                       len;
        int                       idx;
        logic [SDVPS_ID_BITS-1:0] id;
        len = $urandom_range(1, 6);
        idx = 0;
        id  = SDVPS_ID_BITS'($urandom_range(0, 40));
        for (int k = 0; k < len; k++)
        begin
            if (sb.ids.size() > idx && $urandom_range(0, 3) != 0)
            begin
                idx = $urandom_range(idx, sb.ids.size() - 1);
                id  = sb.ids[idx];
                idx++;
            end
            else
                id = id + SDVPS_ID_BITS'($urandom_range(1, 300));
            issue(make_op(add_or_sub(), id, rand_memb(), rand_base(), k == len - 1));
        end
    endtask

    task automatic run_random(int quota);
        int start;
        int kind;
        int len;
        start = items_sent;
        while (items_sent - start < quota)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 28)
            begin
                if (sb.full() && coin())
                    issue(make_op(ACT_CLEAR, fresh_id(), rand_memb(), $urandom, coin()));
                len = $urandom_range(1, 4);
                repeat (len)
                    issue(make_op(ACT_INSERT, fresh_id(), rand_memb(), $urandom, coin()));
            end
            else if (kind < 62)
                ordered_pattern();
            else if (kind < 76)
                issue(make_op(ACT_LOOKUP, known_or_fresh(), rand_memb(), $urandom, coin()));
            else if (kind < 82)
            begin
                // pattern interrupted by another action, maybe never closed
                len = $urandom_range(1, 3);
                repeat (len)
                    issue(make_op(add_or_sub(), known_or_fresh(), rand_memb(), rand_base(),
                                  1'b0));
                case ($urandom_range(0, 2))
                    0: issue(make_op(ACT_INSERT, fresh_id(), rand_memb(), $urandom, coin()));
                    1: issue(make_op(ACT_LOOKUP, known_or_fresh(), rand_memb(), $urandom,
                                     coin()));
                    default: issue(make_op(ACT_CLEAR, fresh_id(), rand_memb(), $urandom,
                                           coin()));
                endcase
                if (coin())
                    issue(make_op(add_or_sub(), known_or_fresh(), rand_memb(), rand_base(),
                                  1'b1));
            end
            else if (kind < 85)
                issue(make_op(ACT_CLEAR, fresh_id(), rand_memb(), $urandom, coin()));
            else if (kind < 92)
            begin
                len = $urandom_range(2, 5);
                for (int k = 0; k < len; k++)
                    issue(make_op(add_or_sub(), known_or_fresh(), rand_memb(), rand_base(),
                                  k == len - 1));
            end
            else
                issue(make_op(3'($urandom_range(ACT_RSVD_FIRST, ACT_RSVD_LAST)), fresh_id(),
                              rand_memb(), $urandom, coin()));
        end
    endtask

    initial
    begin : stimulus
        logic [VALUE_W-1:0] dflt;
        logic [VALUE_W-1:0] lim;
        in_valid      = 1'b0;
        action        = ACT_INSERT;
        element_id    = '0;
        membership    = '0;
        base_sum      = '0;
        last          = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_DEFAULT_VALUE;
        cfg_data      = '0;
        rst_n         = 1'b0;
        items_sent    = 0;
        settings_used = 1;
        burst_left    = 0;
        gaps_on       = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset config, empty store, extremes, duplicates
        send(make_op(ACT_LOOKUP, 16'd0, 16'sd0, 32'sd0, 1'b0));
        send(make_op(ACT_INSERT, 16'hFFFF, 16'sh7FFF, 32'sd0, 1'b1));
        send(make_op(ACT_INSERT, 16'd0, 16'sh8000, 32'sd0, 1'b0));
        send(make_op(ACT_INSERT, 16'd100, -16'sd1, 32'sd0, 1'b0));
        send(make_op(ACT_INSERT, 16'd100, 16'sd7, 32'sd0, 1'b0));
        send(make_op(ACT_LOOKUP, 16'd100, 16'sd0, 32'sd0, 1'b0));
        // pattern with an insert and a lookup in the middle, from the largest base
        send(make_op(ACT_ADD, 16'd0, 16'sd0, 32'sh7FFF_FFFF, 1'b0));
        send(make_op(ACT_INSERT, 16'd50, 16'sd3, 32'sd0, 1'b0));
        send(make_op(ACT_LOOKUP, 16'd50, 16'sd0, 32'sd0, 1'b0));
        send(make_op(ACT_SUB, 16'd100, 16'sd0, 32'sd0, 1'b0));
        send(make_op(ACT_ADD, 16'hFFFF, 16'sd0, 32'sd0, 1'b1));
        // single-id pattern on an absent id
        send(make_op(ACT_SUB, 16'd7, 16'sd0, 32'sh8000_0000, 1'b1));
        // unordered ids, mixed signs
        send(make_op(ACT_ADD, 16'hFFFF, 16'sd0, 32'sd1, 1'b0));
        send(make_op(ACT_SUB, 16'd0, 16'sd0, 32'sd0, 1'b0));
        send(make_op(ACT_ADD, 16'd50, 16'sd0, 32'sd0, 1'b1));
        // clear drops the open pattern
        send(make_op(ACT_ADD, 16'd0, 16'sd0, 32'sd9, 1'b0));
        send(make_op(ACT_CLEAR, 16'd0, 16'sd0, 32'sd0, 1'b0));
        send(make_op(ACT_ADD, 16'd0, 16'sd0, 32'sd5, 1'b1));
        for (int a = ACT_RSVD_FIRST; a <= ACT_RSVD_LAST; a++)
            send(make_op(3'(a), 16'hFFFF, 16'sh7FFF, 32'sh7FFF_FFFF, 1'b1));
        quiesce();

        // small limit: fill, then refuse
        program_reg(REG_SIZE_LIMIT, 16'd2);
        program_reg(REG_DEFAULT_VALUE, 16'h8000);
        settings_used++;
        send(make_op(ACT_INSERT, 16'd10, 16'sd1, 32'sd0, 1'b0));
        send(make_op(ACT_INSERT, 16'd20, 16'sd2, 32'sd0, 1'b0));
        send(make_op(ACT_INSERT, 16'd30, 16'sd3, 32'sd0, 1'b0));
        send(make_op(ACT_LOOKUP, 16'd99, 16'sd0, 32'sd0, 1'b0));
        quiesce();
        // limit lowered below the stored count
        program_reg(REG_SIZE_LIMIT, 16'd0);
        settings_used++;
        send(make_op(ACT_INSERT, 16'd5, 16'sd4, 32'sd0, 1'b0));
        send(make_op(ACT_LOOKUP, 16'd20, 16'sd0, 32'sd0, 1'b0));
        quiesce();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: begin dflt = 16'h7FFF; lim = 16'd64; end
                1: begin dflt = VALUE_W'($urandom); lim = 16'd5; end
                2: begin dflt = 16'hFFFF; lim = 16'd1;  end
                3: begin dflt = VALUE_W'($urandom); lim = VALUE_W'($urandom_range(1, 63)); end
                4: begin dflt = 16'h8000; lim = 16'd64; end
                5: begin dflt = 16'h0000; lim = 16'd3;  end
                6: begin dflt = VALUE_W'($urandom); lim = 16'd0; end
                default: begin dflt = VALUE_W'($urandom); lim = 16'd64; end
            endcase
            program_reg(REG_DEFAULT_VALUE, dflt);
            program_reg(REG_SIZE_LIMIT, lim);
            settings_used++;
            gaps_on    = (p % 3) != 0;
            burst_left = 0;
            run_random(PHASE_ITEMS);
            quiesce();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        sb.check_drained();
        $display("Sent %0d items under %0d register settings; %0d results checked.",
                 items_sent, settings_used, sb.results_seen);
        $display("Inserts refused on a full store: %0d.", sb.rejects_seen);
        if (sb.failures == 0)
            $display("sparse_default_vector_pattern_sum test passed");
        else
            $display("sparse_default_vector_pattern_sum test failed");
        $finish;
    end

endmodule

// ===== sparse_default_vector_pattern_sum.f =====
+incdir+rtl
rtl/sdvps_pkg.sv
rtl/sdvps_cell.sv
rtl/sparse_default_vector_pattern_sum.sv
bench/testbench.sv
